// ----- hdl/qmm_pkg.sv -----
package qmm_pkg;

	// operation codes carried by a command beat
	typedef enum logic [2:0] {
		OP_SET_THROTTLE = 3'd0,
		OP_SET_PITCH_ROLL = 3'd1,
		OP_SET_YAW = 3'd2,
		OP_REFRESH = 3'd3,
		OP_ARM = 3'd4,
		OP_DISARM = 3'd5
	} opcode_t;

	typedef logic [6:0] pct_t;

	localparam int unsigned PCT_MAX = 100;
	// bias that turns an arithmetic shift by two into a truncating divide by four
	localparam int unsigned DIV4_BIAS = 3;

endpackage

// ----- hdl/qmm_if.sv -----
interface qmm_cmd_if #(
	parameter int unsigned COMMAND_BITS = 8
);
	import qmm_pkg::*;

	logic valid;
	logic ready;
	logic [2:0] opcode;
	pct_t throttle_in;
	logic signed [COMMAND_BITS-1:0] pitch_in;
	logic signed [COMMAND_BITS-1:0] roll_in;
	logic signed [COMMAND_BITS-1:0] yaw_in;

	modport source (
		output valid, opcode, throttle_in, pitch_in, roll_in, yaw_in,
		input ready
	);
	modport sink (
		input valid, opcode, throttle_in, pitch_in, roll_in, yaw_in,
		output ready
	);
endinterface

interface qmm_pwr_if;
	import qmm_pkg::*;

	logic valid;
	logic ready;
	pct_t power_front_left;
	pct_t power_front_right;
	pct_t power_rear_right;
	pct_t power_rear_left;
	logic armed_out;

	modport source (
		output valid, power_front_left, power_front_right, power_rear_right,
		power_rear_left, armed_out,
		input ready
	);
	modport sink (
		input valid, power_front_left, power_front_right, power_rear_right,
		power_rear_left, armed_out,
		output ready
	);
endinterface

// ----- hdl/quad_motor_mixer_top.sv -----
// a command beat accepted goes into the setpoint stage, then the output register gives its power beat
// throughput: one command beat per cycle, limited only by the sink taking power beats
// a full output register stalls the command side only when the sink holds ready low
// reset (arst_n low, asynchronous): setpoints zero, motors disarmed, both stages empty
module quad_motor_mixer_top
	import qmm_pkg::*;
#(
	parameter int unsigned COMMAND_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	qmm_cmd_if.sink cmd,
	qmm_pwr_if.source pwr
);

	// mix sum of three commands needs two extra bits
	localparam int unsigned MW = COMMAND_BITS + 2;
	// motor value before desaturation, and after the shift, with headroom
	localparam int unsigned BW = (COMMAND_BITS > 8) ? COMMAND_BITS : 8;
	localparam int unsigned PW = BW + 3;

	// stage 1: setpoint state, updated as a command beat is taken
	pct_t throttle_q;
	logic signed [COMMAND_BITS-1:0] pitch_q;
	logic signed [COMMAND_BITS-1:0] roll_q;
	logic signed [COMMAND_BITS-1:0] yaw_q;
	logic armed_q;
	logic valid_s1;

	// stage 2: output register
	logic valid_s2;
	pct_t power_s2 [4];
	logic armed_s2;

	logic advance;
	logic take;

	// stage 1 moves on when the output register is empty or being drained
	assign advance = !valid_s2 || pwr.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign take = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q <= '0;
			pitch_q <= '0;
			roll_q <= '0;
			yaw_q <= '0;
			armed_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				// unused codes fall through as a refresh
				unique case (cmd.opcode)
					OP_SET_THROTTLE: begin
						throttle_q <= cmd.throttle_in;
					end
					OP_SET_PITCH_ROLL: begin
						pitch_q <= cmd.pitch_in;
						roll_q <= cmd.roll_in;
					end
					OP_SET_YAW: begin
						yaw_q <= cmd.yaw_in;
					end
					OP_ARM: begin
						throttle_q <= '0;
						pitch_q <= '0;
						roll_q <= '0;
						yaw_q <= '0;
						armed_q <= 1'b1;
					end
					OP_DISARM: begin
						throttle_q <= '0;
						pitch_q <= '0;
						roll_q <= '0;
						yaw_q <= '0;
						armed_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// mixing from the setpoints as they stand after the item in stage 1
	logic signed [MW-1:0] p_x, r_x, y_x;
	logic signed [MW-1:0] mix [4];
	logic signed [MW-1:0] biased [4];
	logic signed [MW-1:0] quot [4];
	logic signed [PW-1:0] motor [4];
	logic signed [PW-1:0] hi01, hi23, lo01, lo23, hi, lo;
	logic signed [PW-1:0] shift;
	logic signed [PW-1:0] shifted [4];
	pct_t clamped [4];
	logic motors_off;

	always_comb begin
		p_x = MW'(pitch_q);
		r_x = MW'(roll_q);
		y_x = MW'(yaw_q);
		// x frame: front left, front right, rear right, rear left
		mix[0] = -p_x + r_x - y_x;
		mix[1] = -p_x - r_x + y_x;
		mix[2] = p_x - r_x - y_x;
		mix[3] = p_x + r_x + y_x;
		for (int i = 0; i < 4; i++) begin
			// truncate toward zero: bias negatives before the arithmetic shift
			biased[i] = mix[i] + (mix[i][MW-1] ? MW'(signed'(DIV4_BIAS)) : MW'(0));
			quot[i] = biased[i] >>> 2;
			motor[i] = PW'(signed'({1'b0, throttle_q})) + PW'(quot[i]);
		end

		hi01 = (motor[1] > motor[0]) ? motor[1] : motor[0];
		hi23 = (motor[3] > motor[2]) ? motor[3] : motor[2];
		lo01 = (motor[1] < motor[0]) ? motor[1] : motor[0];
		lo23 = (motor[3] < motor[2]) ? motor[3] : motor[2];
		hi = (hi23 > hi01) ? hi23 : hi01;
		lo = (lo23 < lo01) ? lo23 : lo01;

		// both ends out: clamp only; one end out: slide the set back in
		priority if (hi > PW'(PCT_MAX) && lo < 0) begin
			shift = '0;
		end else if (hi > PW'(PCT_MAX)) begin
			shift = hi - PW'(PCT_MAX);
		end else if (lo < 0) begin
			shift = lo;
		end else begin
			shift = '0;
		end

		for (int i = 0; i < 4; i++) begin
			shifted[i] = motor[i] - shift;
			if (shifted[i] < 0) begin
				clamped[i] = '0;
			end else if (shifted[i] > PW'(PCT_MAX)) begin
				clamped[i] = pct_t'(PCT_MAX);
			end else begin
				clamped[i] = shifted[i][6:0];
			end
		end

		motors_off = !armed_q || (throttle_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// payload of the output register needs no reset
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			for (int i = 0; i < 4; i++) begin
				power_s2[i] <= motors_off ? pct_t'(0) : clamped[i];
			end
			armed_s2 <= armed_q;
		end
	end

	assign pwr.valid = valid_s2;
	assign pwr.power_front_left = power_s2[0];
	assign pwr.power_front_right = power_s2[1];
	assign pwr.power_rear_right = power_s2[2];
	assign pwr.power_rear_left = power_s2[3];
	assign pwr.armed_out = armed_s2;

endmodule

// ----- hdl/qmm_checker.sv -----
module qmm_checker
	import qmm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic [2:0] cmd_opcode,
	input logic pwr_valid,
	input logic pwr_ready,
	input pct_t pwr_fl,
	input pct_t pwr_fr,
	input pct_t pwr_rr,
	input pct_t pwr_rl,
	input logic pwr_armed
);

	// a stalled power beat stays put
	a_pwr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pwr_valid && !pwr_ready |=> pwr_valid
			&& $stable(pwr_fl) && $stable(pwr_fr) && $stable(pwr_rr) && $stable(pwr_rl)
			&& $stable(pwr_armed))
		else $error("power beat changed while stalled");

	// every power within percent range
	a_pwr_range: assert property (@(posedge clk) disable iff (!arst_n)
		pwr_valid |-> pwr_fl <= pct_t'(PCT_MAX) && pwr_fr <= pct_t'(PCT_MAX)
			&& pwr_rr <= pct_t'(PCT_MAX) && pwr_rl <= pct_t'(PCT_MAX))
		else $error("power above full scale");

	// disarmed motors are off
	a_disarmed_off: assert property (@(posedge clk) disable iff (!arst_n)
		pwr_valid && !pwr_armed |-> pwr_fl == '0 && pwr_fr == '0
			&& pwr_rr == '0 && pwr_rl == '0)
		else $error("disarmed beat with nonzero power");

	// a disarm reaches the output through stage 1 and the output register when the sink keeps up
	a_disarm_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_opcode == OP_DISARM ##1 pwr_ready
			|=> pwr_valid && !pwr_armed)
		else $error("disarm beat not delivered on time");

endmodule

bind quad_motor_mixer_top qmm_checker u_qmm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.cmd_opcode(cmd.opcode),
	.pwr_valid(pwr.valid),
	.pwr_ready(pwr.ready),
	.pwr_fl(pwr.power_front_left),
	.pwr_fr(pwr.power_front_right),
	.pwr_rr(pwr.power_rear_right),
	.pwr_rl(pwr.power_rear_left),
	.pwr_armed(pwr.armed_out)
);

// ----- tb/quad_motor_mixer_top_tb.sv -----
`timescale 1ns / 1ps

module quad_motor_mixer_top_tb;
	import qmm_pkg::*;

	localparam int unsigned CMD_BITS = 8;
	// roughly a third of the cycles idle on either side
	localparam int unsigned IDLE_PCT = 34;
	// cycles with no beat on either channel before the run is given up
	localparam int unsigned STALL_LIMIT = 5000;
	// spare edges after the last expected power beat, to catch any stray one
	localparam int unsigned DRAIN_CYCLES = 4;
	// opcodes with no meaning of their own, handled as a refresh
	localparam bit [2:0] OP_SPARE_6 = 3'd6;
	localparam bit [2:0] OP_SPARE_7 = 3'd7;

	typedef logic signed [CMD_BITS-1:0] cmd_t;

	typedef struct packed {
		pct_t front_left;
		pct_t front_right;
		pct_t rear_right;
		pct_t rear_left;
		logic armed;
	} power_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	qmm_cmd_if #(.COMMAND_BITS(CMD_BITS)) cmd();
	qmm_pwr_if pwr();

	quad_motor_mixer_top #(.COMMAND_BITS(CMD_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.pwr(pwr.source)
	);

	always #5 clk = ~clk;

	// mixer state as the predictor sees it
	pct_t mix_throttle = '0;
	cmd_t mix_pitch = '0;
	cmd_t mix_roll = '0;
	cmd_t mix_yaw = '0;
	bit mix_armed = 1'b0;

	power_beat_t expected_powers[$];
	int unsigned errors = 0;
	// set while both sides are to run without any idling
	bit steady_flow = 1'b0;

	function automatic int clamp_pct(int v);
		if (v < 0)
			return 0;
		if (v > int'(PCT_MAX))
			return int'(PCT_MAX);
		return v;
	endfunction

	// applies one command to the setpoints, then mixes and desaturates the four motors
	function automatic power_beat_t mix_command(bit [2:0] op, pct_t thr, cmd_t p, cmd_t r,
			cmd_t y);
		int t;
		int sp;
		int sr;
		int sy;
		int pw[4];
		int hi;
		int lo;
		int shift;
		power_beat_t beat;

		case (op)
			OP_SET_THROTTLE: mix_throttle = thr;
			OP_SET_PITCH_ROLL: begin
				mix_pitch = p;
				mix_roll = r;
			end
			OP_SET_YAW: mix_yaw = y;
			OP_ARM: begin
				mix_throttle = '0; mix_pitch = '0; mix_roll = '0; mix_yaw = '0;
				mix_armed = 1'b1;
			end
			OP_DISARM: begin
				mix_throttle = '0; mix_pitch = '0; mix_roll = '0; mix_yaw = '0;
				mix_armed = 1'b0;
			end
			default: ;
		endcase

		if (!mix_armed || mix_throttle == 0) begin
			foreach (pw[i])
				pw[i] = 0;
		end else begin
			t = int'(mix_throttle);
			sp = int'(mix_pitch);
			sr = int'(mix_roll);
			sy = int'(mix_yaw);
			// int division truncates toward zero
			pw[0] = t + (-sp + sr - sy) / 4;
			pw[1] = t + (-sp - sr + sy) / 4;
			pw[2] = t + (sp - sr - sy) / 4;
			pw[3] = t + (sp + sr + sy) / 4;
			hi = pw[0];
			lo = pw[0];
			for (int i = 1; i < 4; i++) begin
				if (pw[i] > hi) hi = pw[i];
				if (pw[i] < lo) lo = pw[i];
			end
			// saturated on both ends: plain clamp; one end only: shift the set back in
			shift = 0;
			if (hi > int'(PCT_MAX) && lo < 0)
				shift = 0;
			else if (hi > int'(PCT_MAX))
				shift = hi - int'(PCT_MAX);
			else if (lo < 0)
				shift = lo;
			foreach (pw[i])
				pw[i] = clamp_pct(pw[i] - shift);
		end

		beat.front_left = pct_t'(pw[0]);
		beat.front_right = pct_t'(pw[1]);
		beat.rear_right = pct_t'(pw[2]);
		beat.rear_left = pct_t'(pw[3]);
		beat.armed = mix_armed;
		return beat;
	endfunction

	// drives one command beat from the falling edge, holds it until taken, then predicts it
	task automatic send_command(bit [2:0] op, pct_t thr, cmd_t p, cmd_t r, cmd_t y);
		bit taken;

		@(negedge clk);
		while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.opcode <= op;
		cmd.throttle_in <= thr;
		cmd.pitch_in <= p;
		cmd.roll_in <= r;
		cmd.yaw_in <= y;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = cmd.ready;
		end
		expected_powers.push_back(mix_command(op, thr, p, r, y));
	endtask

	function automatic cmd_t random_cmd();
		// half the time small, so that the mix often needs no desaturation
		if ($urandom_range(0, 1))
			return cmd_t'($urandom_range(0, 255));
		return cmd_t'(int'($urandom_range(0, 80)) - 40);
	endfunction

	function automatic pct_t random_throttle();
		int unsigned pick;

		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return pct_t'($urandom_range(101, 127));
		return pct_t'($urandom_range(1, 100));
	endfunction

	// mostly setpoint updates on an armed mixer, with the odd refresh, spare opcode, disarm or re-arm
	task automatic send_flight_item();
		int unsigned pick;
		bit [2:0] op;

		pick = $urandom_range(0, 99);
		if (!mix_armed)
			op = OP_ARM;
		else if (pick < 30)
			op = OP_SET_THROTTLE;
		else if (pick < 60)
			op = OP_SET_PITCH_ROLL;
		else if (pick < 80)
			op = OP_SET_YAW;
		else if (pick < 92)
			op = OP_REFRESH;
		else if (pick < 95)
			op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
		else if (pick < 97)
			op = OP_DISARM;
		else
			op = OP_ARM;
		send_command(op, random_throttle(), random_cmd(), random_cmd(), random_cmd());
	endtask

	// outputs stay zero while disarmed, whatever the setpoints
	task automatic test_disarmed_after_reset();
		send_command(OP_REFRESH, '0, '0, '0, '0);
		send_command(OP_SET_THROTTLE, pct_t'(PCT_MAX), '0, '0, '0);
		send_command(OP_SET_PITCH_ROLL, '0, 8'sd127, -8'sd128, '0);
	endtask

	// arming and disarming both wipe the setpoints
	task automatic test_arm_disarm();
		send_command(OP_ARM, '0, '0, '0, '0);
		send_command(OP_SET_THROTTLE, 7'd60, '0, '0, '0);
		send_command(OP_DISARM, '0, '0, '0, '0);
		send_command(OP_REFRESH, '0, '0, '0, '0);
	endtask

	task automatic test_desaturation();
		send_command(OP_ARM, '0, '0, '0, '0);
		// saturated high and low at once: clamp only
		send_command(OP_SET_THROTTLE, 7'd50, '0, '0, '0);
		send_command(OP_SET_PITCH_ROLL, '0, 8'sd127, 8'sd127, '0);
		// high side only: shift down
		send_command(OP_SET_THROTTLE, pct_t'(PCT_MAX), '0, '0, '0);
		send_command(OP_SET_PITCH_ROLL, '0, '0, '0, '0);
		send_command(OP_SET_YAW, '0, '0, '0, 8'sd127);
		// low side only: shift up
		send_command(OP_SET_THROTTLE, 7'd10, '0, '0, '0);
		send_command(OP_SET_YAW, '0, '0, '0, -8'sd128);
		// throttle above full scale, then a shift that still leaves one motor below zero
		send_command(OP_SET_YAW, '0, '0, '0, '0);
		send_command(OP_SET_THROTTLE, 7'd127, '0, '0, '0);
		send_command(OP_SET_PITCH_ROLL, '0, -8'sd128, -8'sd128, '0);
		send_command(OP_SET_YAW, '0, '0, '0, -8'sd128);
		// zero throttle while armed
		send_command(OP_SET_THROTTLE, '0, '0, '0, '0);
		// small negative mix must truncate toward zero, not round down
		send_command(OP_SET_THROTTLE, 7'd50, '0, '0, '0);
		send_command(OP_SET_PITCH_ROLL, '0, 8'sd3, -8'sd3, '0);
		send_command(OP_SET_YAW, '0, '0, '0, 8'sd1);
	endtask

	// spare opcodes leave the setpoints alone
	task automatic test_spare_opcodes();
		send_command(OP_SPARE_6, 7'd127, -8'sd128, 8'sd127, -8'sd128);
		send_command(OP_SPARE_7, 7'd85, 8'sd127, -8'sd128, 8'sd127);
	endtask

	task automatic test_random_flight(int unsigned n);
		repeat (n)
			send_flight_item();
	endtask

	// a stretch with no idling on either side
	task automatic test_back_to_back(int unsigned n);
		steady_flow = 1'b1;
		repeat (n)
			send_flight_item();
		steady_flow = 1'b0;
	endtask

	// anything at all, spare opcodes and out of range throttle included
	task automatic test_noise(int unsigned n);
		repeat (n)
			send_command(3'($urandom_range(0, 7)), pct_t'($urandom_range(0, 127)),
				cmd_t'($urandom_range(0, 255)), cmd_t'($urandom_range(0, 255)),
				cmd_t'($urandom_range(0, 255)));
	endtask

	// power sink: random back-pressure, driven from the falling edge
	initial begin
		pwr.ready = 1'b0;
		forever begin
			@(negedge clk);
			pwr.ready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// every power beat taken is compared against the oldest prediction
	always @(posedge clk) begin
		power_beat_t want;

		if (arst_n && pwr.valid && pwr.ready) begin
			if (expected_powers.size() == 0) begin
				$error("power beat with no command outstanding");
				errors++;
			end else begin
				want = expected_powers.pop_front();
				check_field("power_front_left", want.front_left, pwr.power_front_left);
				check_field("power_front_right", want.front_right, pwr.power_front_right);
				check_field("power_rear_right", want.rear_right, pwr.power_rear_right);
				check_field("power_rear_left", want.rear_left, pwr.power_rear_left);
				check_field("armed_out", 7'(want.armed), 7'(pwr.armed_out));
			end
		end
	end

	// watchdog: gives up once neither channel has moved a beat for too long
	initial begin
		int unsigned quiet_cycles;

		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (pwr.valid && pwr.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[quad_motor_mixer_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		cmd.valid = 1'b0;
		cmd.opcode = OP_REFRESH;
		cmd.throttle_in = '0;
		cmd.pitch_in = '0;
		cmd.roll_in = '0;
		cmd.yaw_in = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_disarmed_after_reset();
		test_arm_disarm();
		test_desaturation();
		test_spare_opcodes();
		test_random_flight(550);
		test_back_to_back(200);
		test_noise(150);

		@(negedge clk);
		cmd.valid <= 1'b0;
		// let the last power beats drain, then keep watching to catch any stray one
		while (expected_powers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[quad_motor_mixer_top] OK");
		else
			$display("[quad_motor_mixer_top] ERROR");
		$finish;
	end

endmodule
